### design/sb2da_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
package sb2da_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_CHARS_DEF  = 20;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// BCD shift-and-add-3 threshold and correction
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;
	localparam logic [3:0] BCD_MAX     = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_ALIGN,
		ST_EMIT
	} state_t;

	// Command to every digit cell
	typedef struct packed {
		logic clr;    // zero the digit
		logic conv;   // add-3 correction, then shift one bit in
		logic shift;  // take the lower neighbor's digit
	} cell_ctrl_t;

endpackage

### design/sb2da_cell.sv
// One BCD digit cell of the double-dabble chain.
module sb2da_cell (
	input  logic                   clk,
	input  sb2da_pkg::cell_ctrl_t  ctrl,
	input  logic                   bit_in,
	input  logic [3:0]             digit_in,
	output logic                   carry_out,
	output logic [3:0]             digit
);
	import sb2da_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Correct the digit so a left shift carries into the next decade
	always_comb begin
		adj       = (digit_q >= BCD_ADJ_MIN) ? (digit_q + BCD_ADJ) : digit_q;
		carry_out = adj[3];
	end

	// Clear, shift a bit in, or take the neighbor's digit
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

	assign digit = digit_q;

endmodule

### design/sb2da_chain.sv
// Row of BCD digit cells; bits and digits move toward the most significant end.
module sb2da_chain #(
	parameter int DIGITS = 20
) (
	input  logic                   clk,
	input  sb2da_pkg::cell_ctrl_t  ctrl,
	input  logic                   bit_in,
	output logic [3:0]             top_digit
);
	import sb2da_pkg::*;

	logic [DIGITS-1:0]      carry;
	logic [3:0]             digit [DIGITS];

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		logic       cell_bit;
		logic [3:0] cell_digit;

		// Lowest cell is fed from the magnitude register and with zero digits
		if (i == 0) begin : g_first
			assign cell_bit   = bit_in;
			assign cell_digit = '0;
		end else begin : g_rest
			assign cell_bit   = carry[i-1];
			assign cell_digit = digit[i-1];
		end

		sb2da_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.bit_in    (cell_bit),
			.digit_in  (cell_digit),
			.carry_out (carry[i]),
			.digit     (digit[i])
		);
	end

	assign top_digit = digit[DIGITS-1];

endmodule

### design/signed_binary_to_decimal_ascii.sv
// Sequence: after the accept, VALUE_BITS conversion steps, then alignment shifts that drop
// leading zero digits, then the sign (if negative) and the digits, one character per word.
// Only one word is converted at a time; output stalls hold the emission. Reset: arst_n
// clears the sequencer and the output valid.
// Top level: converts a signed integer to its decimal text, one character per word.
module signed_binary_to_decimal_ascii #(
	parameter int VALUE_BITS = sb2da_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS  = sb2da_pkg::MAX_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_ready,
	input  logic signed [63:0] value,
	output logic               char_valid,
	input  logic               char_ready,
	output logic [7:0]         char_code,
	output logic               last
);
	import sb2da_pkg::*;

	// Digits needed for any VALUE_BITS-bit magnitude: ceil(VALUE_BITS * log10(2))
	localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int ND_W   = $clog2(DIGITS + 1);
	localparam int SENT_W = $clog2(MAX_CHARS + 1);

	state_t              state_q, state_d;
	logic [VALUE_BITS-1:0] mag_q;
	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                neg_q;
	logic                sign_pend_q;
	logic [CNT_W-1:0]    bit_cnt_q;
	logic [ND_W-1:0]     nd_q;
	logic [SENT_W-1:0]   sent_q;
	logic                char_valid_q;
	logic [7:0]          char_code_q;
	logic                last_q;

	cell_ctrl_t          ctrl;
	logic [3:0]          top_digit;
	logic                accept;
	logic                load_char;
	logic                is_last;

	// Magnitude of the low VALUE_BITS bits, unsigned
	always_comb begin
		v_in   = value[VALUE_BITS-1:0];
		mag_in = v_in[VALUE_BITS-1] ? VALUE_BITS'(~v_in + VALUE_BITS'(1)) : v_in;
	end

	sb2da_chain #(
		.DIGITS (DIGITS)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.bit_in    (mag_q[VALUE_BITS-1]),
		.top_digit (top_digit)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell commands
	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		value_ready = 1'b0;
		accept      = 1'b0;
		load_char   = 1'b0;
		is_last     = (nd_q == ND_W'(1)) || (sent_q == SENT_W'(MAX_CHARS - 1));
		unique case (state_q)
			ST_IDLE: begin
				value_ready = 1'b1;
				accept      = value_valid;
				ctrl.clr    = value_valid;
				if (value_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.conv = 1'b1;
				if (bit_cnt_q == CNT_W'(1)) begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (top_digit == '0 && nd_q != ND_W'(1)) begin
					ctrl.shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				load_char = !char_valid_q || char_ready;
				if (load_char && !sign_pend_q) begin
					ctrl.shift = 1'b1;
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control counters and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q    <= '0;
			nd_q         <= '0;
			sent_q       <= '0;
			sign_pend_q  <= 1'b0;
			char_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				bit_cnt_q <= CNT_W'(VALUE_BITS);
			end else if (ctrl.conv) begin
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
			end

			if (state_q == ST_CONV) begin
				nd_q        <= ND_W'(DIGITS);
				sent_q      <= '0;
				sign_pend_q <= neg_q;
			end else if (load_char) begin
				sent_q      <= sent_q + SENT_W'(1);
				sign_pend_q <= 1'b0;
				if (!sign_pend_q) begin
					nd_q <= nd_q - ND_W'(1);
				end
			end else if (ctrl.shift) begin
				nd_q <= nd_q - ND_W'(1);
			end

			if (load_char) begin
				char_valid_q <= 1'b1;
			end else if (char_ready) begin
				char_valid_q <= 1'b0;
			end
		end
	end

	// Magnitude shifter and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			neg_q <= v_in[VALUE_BITS-1];
		end else if (ctrl.conv) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end

		if (load_char) begin
			if (sign_pend_q) begin
				char_code_q <= CHAR_MINUS;
				last_q      <= 1'b0;
			end else begin
				char_code_q <= CHAR_ZERO + {4'd0, top_digit};
				last_q      <= is_last;
			end
		end
	end

	assign char_valid = char_valid_q;
	assign char_code  = char_code_q;
	assign last       = last_q;

	// Digit count never runs out while characters are pending
	a_nd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (nd_q != '0))
		else $error("digit count empty during emission");

	// Alignment stops on a nonzero leading digit unless only one digit is left
	a_align_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALIGN && state_d == ST_EMIT) |-> (top_digit != '0 || nd_q == ND_W'(1)))
		else $error("leading zero left after alignment");

	// Sign character is never the final one
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid_q && char_code_q == CHAR_MINUS) |-> !last_q)
		else $error("sign flagged as last character");

	// Emitted digits are decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && load_char && !sign_pend_q) |-> (top_digit <= BCD_MAX))
		else $error("digit cell holds a non-decimal value");

endmodule
